/* rtl/tpd_pkg.sv */
// Package for the tuple packet deframer: sizes, frame patterns, operation
// and state types shared by the front, queue and back modules.
// Depends on nothing.
`default_nettype none

package tpd_pkg;

   // Frame geometry.
   localparam int WINDOW_BYTES   = 1024;
   localparam int MAX_DATA_WORDS = 16;
   localparam int STORE_DEPTH    = MAX_DATA_WORDS + 2;
   localparam int TUPLE_BYTES    = 5;

   // Derived widths.
   localparam int ADDR_W  = $clog2(STORE_DEPTH);
   localparam int COUNT_W = $clog2(STORE_DEPTH + 1);
   localparam int WIN_W   = $clog2(WINDOW_BYTES);
   localparam int PHASE_W = $clog2(TUPLE_BYTES);

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Five-byte markers, newest byte lowest.
   localparam logic [39:0] HEADER_PATTERN = 40'hFE_FFFF_FFFF;
   localparam logic [39:0] FOOTER_PATTERN = 40'hFF_FFFF_FFFF;

   typedef enum logic {
      OP_STORE,
      OP_EMIT
   } op_kind_type;

   // One queued operation: store a word at addr, or read out entries 0..addr.
   typedef struct packed {
      op_kind_type       kind;
      logic [ADDR_W-1:0] addr;
      logic [31:0]       data;
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } queue_head_type;

   typedef enum logic [1:0] {
      KIND_CMD  = 2'd0,
      KIND_LEN  = 2'd1,
      KIND_DATA = 2'd2
   } word_kind_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_EMIT
   } back_state_type;

endpackage

`default_nettype wire

/* rtl/tpd_channel_if.sv */
// Channel interfaces for the tuple packet deframer: received bytes in,
// packet words out. Depends on nothing.
`default_nettype none

interface tpd_byte_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tpd_word_if;
   logic               valid;
   logic               ready;
   logic [1:0]         word_kind;
   logic signed [31:0] word_value;
   logic [3:0]         data_index;
   logic               last_word;

   modport source (output valid, output word_kind, output word_value,
                   output data_index, output last_word, input ready);
   modport sink   (input valid, input word_kind, input word_value,
                   input data_index, input last_word, output ready);
endinterface

`default_nettype wire

/* rtl/tpd_front.sv */
// Front of the deframer: accepts bytes, tracks the window, header and tuple
// phase, and turns them into store and emit operations. Uses tpd_pkg.
`default_nettype none

module tpd_front
   import tpd_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   byte_valid,
   input  wire logic [7:0] byte_data,
   output logic        byte_ready,
   input  wire logic   queue_full,
   output logic        push,
   output op_type      push_op
);

   logic [39:0]        recent_ff, recent_in;
   logic [WIN_W-1:0]   win_ff, win_in;
   logic               hdr_ff, hdr_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [COUNT_W-1:0] wcount_ff, wcount_in;
   logic               ovf_ff, ovf_in;

   logic               accept;
   logic               full_win;
   logic [PHASE_W-1:0] phase_next;
   logic [39:0]        shifted;

   assign byte_ready = !queue_full;
   assign accept     = byte_valid && byte_ready;
   assign shifted    = {recent_ff[31:0], byte_data};
   assign full_win   = win_ff >= WIN_W'(4);

   // Tuple phase counts bytes since the header modulo the tuple size.
   always_comb begin
      if (!hdr_ff) begin
         phase_next = phase_ff;
      end else if (phase_ff == PHASE_W'(TUPLE_BYTES - 1)) begin
         phase_next = '0;
      end else begin
         phase_next = phase_ff + PHASE_W'(1);
      end
   end

   // Byte classification and operation generation.
   always_comb begin
      recent_in = recent_ff;
      win_in    = win_ff;
      hdr_in    = hdr_ff;
      phase_in  = phase_ff;
      wcount_in = wcount_ff;
      ovf_in    = ovf_ff;
      push      = 1'b0;
      push_op   = '{kind: OP_STORE, addr: '0, data: shifted[31:0]};

      if (accept) begin
         recent_in = shifted;
         if (full_win && shifted == FOOTER_PATTERN) begin
            // A valid frame ends one byte past a tuple and holds two or more tuples.
            if (hdr_ff && phase_next == PHASE_W'(1) && wcount_ff >= COUNT_W'(3)) begin
               push         = 1'b1;
               push_op.kind = OP_EMIT;
               if (ovf_ff) begin
                  push_op.addr = ADDR_W'(STORE_DEPTH - 1);
               end else begin
                  push_op.addr = ADDR_W'(wcount_ff - COUNT_W'(2));
               end
            end
            win_in    = '0;
            hdr_in    = 1'b0;
            phase_in  = '0;
            wcount_in = '0;
            ovf_in    = 1'b0;
         end else begin
            if (full_win && shifted == HEADER_PATTERN) begin
               hdr_in    = 1'b1;
               phase_in  = '0;
               wcount_in = '0;
               ovf_in    = 1'b0;
            end else begin
               phase_in = phase_next;
               // The last byte of each tuple completes a word.
               if (hdr_ff && phase_next == '0) begin
                  if (wcount_ff < COUNT_W'(STORE_DEPTH)) begin
                     push         = 1'b1;
                     push_op.kind = OP_STORE;
                     push_op.addr = wcount_ff[ADDR_W-1:0];
                     wcount_in    = wcount_ff + COUNT_W'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
            end
            // Window overflow forgets any header.
            if (win_ff == WIN_W'(WINDOW_BYTES - 1)) begin
               win_in    = '0;
               hdr_in    = 1'b0;
               phase_in  = '0;
               wcount_in = '0;
               ovf_in    = 1'b0;
            end else begin
               win_in = win_ff + WIN_W'(1);
            end
         end
      end
   end

   // Shift register of recent bytes needs no reset: matches wait for a full window.
   always_ff @(posedge clock) begin
      recent_ff <= recent_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff    <= '0;
         hdr_ff    <= 1'b0;
         phase_ff  <= '0;
         wcount_ff <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         win_ff    <= win_in;
         hdr_ff    <= hdr_in;
         phase_ff  <= phase_in;
         wcount_ff <= wcount_in;
         ovf_ff    <= ovf_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/tpd_queue.sv */
// Short operation queue between the deframer front and back.
// Uses tpd_pkg for the operation type and depth.
`default_nettype none

module tpd_queue
   import tpd_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  wire op_type push_op,
   output logic        full,
   input  wire logic   pop,
   output queue_head_type head
);

   op_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign head.valid = count_ff != '0;
   assign head.op    = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head.valid;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/tpd_back.sv */
// Back of the deframer: executes queued operations, holds the word store
// and reads packets out through the output register. Uses tpd_pkg.
`default_nettype none

module tpd_back
   import tpd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire queue_head_type head,
   output logic         pop,
   tpd_word_if.source   rsp_chan
);

   back_state_type     state_ff, state_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [ADDR_W-1:0]  last_ff, last_in;
   logic [31:0]        store_ff [STORE_DEPTH];

   logic               out_valid_ff, out_valid_in;
   logic [1:0]         out_kind_ff, out_kind_in;
   logic [31:0]        out_value_ff;
   logic [3:0]         out_index_ff, out_index_in;
   logic               out_last_ff, out_last_in;

   logic               out_free;
   logic               out_load;
   logic               store_we;
   logic [ADDR_W+3:0]  data_pos;
   word_kind_type      kind;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign data_pos = {4'b0, idx_ff} - (ADDR_W + 4)'(2);

   // Word kind follows the position in the packet.
   always_comb begin
      if (idx_ff == ADDR_W'(0)) begin
         kind = KIND_CMD;
      end else if (idx_ff == ADDR_W'(1)) begin
         kind = KIND_LEN;
      end else begin
         kind = KIND_DATA;
      end
   end

   // Operation sequencer and output register load.
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      pop          = 1'b0;
      store_we     = 1'b0;
      out_load     = 1'b0;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_kind_in  = out_kind_ff;
      out_index_in = out_index_ff;
      out_last_in  = out_last_ff;

      unique case (state_ff)
         BACK_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               if (head.op.kind == OP_STORE) begin
                  store_we = 1'b1;
               end else begin
                  idx_in   = '0;
                  last_in  = head.op.addr;
                  state_in = BACK_EMIT;
               end
            end
         end
         BACK_EMIT: begin
            if (out_free) begin
               out_load     = 1'b1;
               out_valid_in = 1'b1;
               out_kind_in  = kind;
               out_index_in = (kind == KIND_DATA) ? data_pos[3:0] : 4'd0;
               out_last_in  = idx_ff == last_ff;
               if (idx_ff == last_ff) begin
                  state_in = BACK_IDLE;
               end else begin
                  idx_in = idx_ff + ADDR_W'(1);
               end
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   // Word store: written by store operations, read into the output register.
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[head.op.addr] <= head.op.data;
      end
      if (out_load) begin
         out_value_ff <= store_ff[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      last_ff      <= last_in;
      out_kind_ff  <= out_kind_in;
      out_index_ff <= out_index_in;
      out_last_ff  <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.word_kind  = out_kind_ff;
   assign rsp_chan.word_value = out_value_ff;
   assign rsp_chan.data_index = out_index_ff;
   assign rsp_chan.last_word  = out_last_ff;

endmodule

`default_nettype wire

/* rtl/tuple_packet_deframer_unit.sv */
// Top level of the tuple packet deframer: front, operation queue and back.
// Uses tpd_pkg, tpd_byte_if, tpd_word_if, tpd_front, tpd_queue, tpd_back.
//
// Usage:
//   req_chan carries one received byte per request (rx_byte). rsp_chan
//   carries the words of each recovered packet: the command word, the
//   length word, then the data words, with last_word set on the final one.
//   Bytes that complete a tuple or a footer place at most one operation in a
//   four-entry queue. The back writes stored words and reads a packet out
//   at one word per cycle while rsp_chan is not stalled.
//   The emit operation for a packet passes through the queue and the back's
//   emit state before its first word is registered for rsp_chan.
//   req_chan.ready falls only while the queue is full, which happens when
//   the receiver stalls rsp_chan or a readout is still in progress; a
//   stalled word stays in the output register until taken.
//   Reset clears the window, the header state, the queue and the output;
//   the word store keeps its contents and is rewritten before any read.
`default_nettype none

module tuple_packet_deframer_unit
   import tpd_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   tpd_byte_if.sink   req_chan,
   tpd_word_if.source rsp_chan
);

   logic           queue_full;
   logic           push;
   op_type         push_op;
   logic           pop;
   queue_head_type head;

   // Byte classification.
   tpd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_chan.valid),
      .byte_data  (req_chan.rx_byte),
      .byte_ready (req_chan.ready),
      .queue_full (queue_full),
      .push       (push),
      .push_op    (push_op)
   );

   // Decoupling queue.
   tpd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .full    (queue_full),
      .pop     (pop),
      .head    (head)
   );

   // Word store and packet readout.
   tpd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

/* verif/tb_tuple_packet_deframer_unit.sv */
// Testbench for tuple_packet_deframer_unit: streams framed and noisy bytes,
// predicts every packet word and checks them in order on the word channel.
// Depends on tpd_pkg, tpd_byte_if, tpd_word_if and the deframer RTL.
`timescale 1ns / 1ps

module tb_tuple_packet_deframer_unit;
   import tpd_pkg::*;

   localparam int LIMIT_CYCLES = 200000;
   localparam int SETTLE_CYCLES = 12;
   localparam logic [7:0] MAX_SEPARATOR = 8'hFD;

   // One planned request, or a marker that pauses until all words are out.
   typedef struct {
      logic [7:0] value;
      bit         wait_drain;
   } planned_byte_type;

   typedef struct {
      word_kind_type kind;
      logic [31:0]   value;
      logic [3:0]    index;
      logic          last;
   } packet_word_type;

   logic clock;
   logic reset;

   tpd_byte_if req_chan ();
   tpd_word_if rsp_chan ();

   tuple_packet_deframer_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   planned_byte_type byte_plan[$];
   packet_word_type  expected_words[$];
   packet_word_type  head_word;

   int  cycle_count = 0;
   int  error_count = 0;
   int  settle_count = 0;
   int  words_taken = 0;
   int  hold_left = 0;
   bit  hold_done = 0;
   wire calm = (cycle_count >= 1000) && (cycle_count < 1800);

   // Mirror of the deframer state.
   logic [39:0] byte_history;
   logic [31:0] word_shift;
   int unsigned window_pos;
   bit          header_open;
   int unsigned since_header;
   int unsigned words_kept;
   logic [31:0] word_mem [STORE_DEPTH];

   task automatic restart_window_state();
      window_pos = 0;
      header_open = 0;
      since_header = 0;
      words_kept = 0;
   endtask

   // Advance the mirror by one accepted byte and queue any packet words.
   task automatic predict_byte(input logic [7:0] b);
      int unsigned     pos;
      bit              full;
      int unsigned     ndata;
      packet_word_type w;
      pos = window_pos;
      full = (pos >= 4);
      byte_history = {byte_history[31:0], b};
      word_shift = {word_shift[23:0], b};
      if (header_open)
         since_header++;
      if (full && byte_history == FOOTER_PATTERN) begin
         // A footer always restarts the window; a well-formed frame emits.
         if (header_open && since_header >= 16 &&
             (since_header - 6) % TUPLE_BYTES == 0) begin
            ndata = (since_header - 6) / TUPLE_BYTES - 2;
            if (ndata > MAX_DATA_WORDS)
               ndata = MAX_DATA_WORDS;
            for (int k = 0; k < ndata + 2; k++) begin
               if (k == 0) begin
                  w.kind = KIND_CMD;
               end else if (k == 1) begin
                  w.kind = KIND_LEN;
               end else begin
                  w.kind = KIND_DATA;
               end
               w.value = word_mem[k];
               w.index = (k >= 2) ? 4'(k - 2) : 4'd0;
               w.last = (k == ndata + 1);
               expected_words.push_back(w);
            end
         end
         restart_window_state();
      end else begin
         if (full && byte_history == HEADER_PATTERN) begin
            header_open = 1;
            since_header = 0;
            words_kept = 0;
         end else if (header_open && since_header % TUPLE_BYTES == 0) begin
            if (words_kept < STORE_DEPTH) begin
               word_mem[words_kept] = word_shift;
               words_kept++;
            end
         end
         window_pos = pos + 1;
         if (window_pos >= WINDOW_BYTES)
            restart_window_state();
      end
   endtask

   // Stimulus building blocks.
   function automatic void plan_byte(input logic [7:0] b);
      planned_byte_type p;
      p.value = b;
      p.wait_drain = 0;
      byte_plan.push_back(p);
   endfunction

   function automatic void plan_drain();
      planned_byte_type p;
      p.value = 8'h00;
      p.wait_drain = 1;
      byte_plan.push_back(p);
   endfunction

   function automatic void plan_pattern(input logic [39:0] pattern);
      for (int i = 4; i >= 0; i--)
         plan_byte(pattern[i*8 +: 8]);
   endfunction

   function automatic void plan_tuple(input logic [7:0] sep, input logic [31:0] word);
      plan_byte(sep);
      for (int i = 3; i >= 0; i--)
         plan_byte(word[i*8 +: 8]);
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Separators stay below FE so that they never merge with a marker.
   function automatic void plan_frame(input int tuples, input int extra);
      plan_pattern(HEADER_PATTERN);
      for (int i = 0; i < tuples; i++)
         plan_tuple(8'($urandom_range(0, MAX_SEPARATOR)), pick_word());
      plan_byte(8'($urandom_range(0, MAX_SEPARATOR)));
      for (int i = 0; i < extra; i++)
         plan_byte(8'($urandom_range(0, MAX_SEPARATOR)));
      plan_pattern(FOOTER_PATTERN);
   endfunction

   // Clock and reset.
   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.rx_byte = 8'h00;
      rsp_chan.ready = 1'b0;
   end

   always #6 clock = ~clock;

   // Cycle count and run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $error("timeout with %0d words still expected", expected_words.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Byte driver: predicts on each accepted request, then offers the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.rx_byte <= 8'h00;
         settle_count = 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            predict_byte(req_chan.rx_byte);
         if (!(req_chan.valid && !req_chan.ready)) begin
            if (byte_plan.size() > 0 && byte_plan[0].wait_drain) begin
               req_chan.valid <= 1'b0;
               if (expected_words.size() == 0)
                  settle_count++;
               else
                  settle_count = 0;
               if (settle_count >= SETTLE_CYCLES) begin
                  settle_count = 0;
                  void'(byte_plan.pop_front());
               end
            end else if (byte_plan.size() > 0 &&
                         (calm || $urandom_range(0, 99) >= 16)) begin
               req_chan.valid <= 1'b1;
               req_chan.rx_byte <= byte_plan[0].value;
               void'(byte_plan.pop_front());
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Word monitor: checks each accepted word and paces the ready signal.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            words_taken++;
            if (expected_words.size() == 0) begin
               $error("unexpected word: kind %0d value %h", rsp_chan.word_kind,
                      rsp_chan.word_value);
               error_count++;
            end else begin
               head_word = expected_words.pop_front();
               if (rsp_chan.word_kind !== head_word.kind) begin
                  $error("word_kind: expected %0d, actual %0d", head_word.kind,
                         rsp_chan.word_kind);
                  error_count++;
               end
               if (rsp_chan.word_value !== head_word.value) begin
                  $error("word_value: expected %h, actual %h", head_word.value,
                         rsp_chan.word_value);
                  error_count++;
               end
               if (rsp_chan.data_index !== head_word.index) begin
                  $error("data_index: expected %0d, actual %0d", head_word.index,
                         rsp_chan.data_index);
                  error_count++;
               end
               if (rsp_chan.last_word !== head_word.last) begin
                  $error("last_word: expected %0d, actual %0d", head_word.last,
                         rsp_chan.last_word);
                  error_count++;
               end
            end
         end
         // One long hold-off lets the queue fill and stall the byte side.
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (!hold_done && words_taken >= 6) begin
            hold_done = 1;
            hold_left = 300;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= calm || $urandom_range(0, 99) >= 16;
         end
      end
   end

   // Stimulus plan and end of run.
   initial begin
      int plan_mark;
      int ndata;
      plan_mark = 0;
      byte_history = '0;
      word_shift = '0;
      restart_window_state();

      // Minimal frame with extreme words: command zero, length all ones.
      plan_pattern(HEADER_PATTERN);
      plan_tuple(8'h00, 32'h0000_0000);
      plan_tuple(8'h7F, 32'hFFFF_FFFF);
      plan_byte(8'h80);
      plan_pattern(FOOTER_PATTERN);
      // Footer without a header; its first four bytes only partly fill the window.
      plan_pattern(FOOTER_PATTERN);
      plan_drain();

      while (byte_plan.size() < 430) begin
         if (plan_mark == 0 && byte_plan.size() > 215) begin
            plan_mark = 1;
            plan_drain();
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               // Well-formed frame, now and then with more data than fits.
               ndata = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20)
                                                   : $urandom_range(0, 4);
               plan_frame(ndata + 2, 0);
            end
            4: plan_frame($urandom_range(0, 1), 0);
            5: plan_frame($urandom_range(2, 5), $urandom_range(1, 4));
            6: begin
               // An older header followed by a newer one that may be misaligned.
               plan_pattern(HEADER_PATTERN);
               for (int i = 0; i < $urandom_range(0, 3); i++)
                  plan_tuple(8'($urandom_range(0, MAX_SEPARATOR)), pick_word());
               for (int i = 0; i < $urandom_range(0, 4); i++)
                  plan_byte(8'($urandom_range(0, MAX_SEPARATOR)));
               plan_frame($urandom_range(1, 4), ($urandom_range(0, 1) == 0) ? 0 : 2);
            end
            default: begin
               for (int i = 0; i < $urandom_range(1, 10); i++)
                  plan_byte(($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom));
            end
         endcase
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (byte_plan.size() > 0 || req_chan.valid);
      do @(posedge clock);
      while (expected_words.size() > 0);
      repeat (20) @(posedge clock);

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

/* tuple_packet_deframer_unit.f */
rtl/tpd_pkg.sv
rtl/tpd_channel_if.sv
rtl/tpd_front.sv
rtl/tpd_queue.sv
rtl/tpd_back.sv
rtl/tuple_packet_deframer_unit.sv
verif/tb_tuple_packet_deframer_unit.sv
